// File: design/kpte_pkg.sv
// kpte_pkg: shared types, event codes and scan-code helpers for the keypad
// tap event classifier. No dependencies.
`default_nettype none

package kpte_pkg;

  localparam int CodeW    = 8;
  localparam int TimeW    = 32;
  localparam int PeriodW  = 16;
  localparam int InDataW  = 40;
  localparam int OutDataW = 40;
  localparam int KindW    = 3;

  localparam logic [CodeW-1:0] NO_KEY = 8'hFF;

  typedef enum logic [KindW-1:0] {
    EV_KEY_DOWN  = 3'd0,
    EV_KEY_UP    = 3'd1,
    EV_MULTI_TAP = 3'd2,
    EV_LONG_TAP  = 3'd3,
    EV_MULTI_KEY = 3'd4
  } ev_t;

  typedef enum logic [0:0] {
    CFG_LONG_PERIOD  = 1'b0,
    CFG_MULTI_WINDOW = 1'b1
  } cfg_idx_t;

  typedef struct packed {
    logic [CodeW-1:0] held_code;
    logic [CodeW-1:0] prior_code;
    logic [CodeW-1:0] older_code;
    logic [7:0]       repeat_count;
    logic [TimeW-1:0] long_deadline;
    logic [TimeW-1:0] repeat_deadline;
    logic             long_armed;
  } state_t;

  typedef struct packed {
    logic [PeriodW-1:0] long_period;
    logic [PeriodW-1:0] multi_window;
  } cfg_t;

  typedef struct packed {
    ev_t              kind;
    logic [CodeW-1:0] key_code;
    logic [CodeW-1:0] previous_code;
    logic [CodeW-1:0] earlier_code;
    logic [3:0]       key_position;
    logic             position_valid;
    logic [7:0]       tap_count;
  } result_t;

  typedef struct packed {
    logic [3:0] pos;
    logic       valid;
  } loc_t;

  // index of the single low bit, bit 2 set when not exactly one
  function automatic logic [2:0] nibble_index(input logic [3:0] nib);
    logic [2:0] idx;
    unique case (nib)
      4'hE:    idx = 3'd0;
      4'hD:    idx = 3'd1;
      4'hB:    idx = 3'd2;
      4'h7:    idx = 3'd3;
      default: idx = 3'd4;
    endcase
    return idx;
  endfunction

  function automatic loc_t locate(input logic [CodeW-1:0] c);
    logic [2:0] r;
    logic [2:0] k;
    loc_t       l;
    r = nibble_index(c[3:0]);
    k = nibble_index(c[7:4]);
    if (!r[2] && !k[2]) begin
      l.pos   = {r[1:0], k[1:0]};
      l.valid = 1'b1;
    end else begin
      l.pos   = 4'd0;
      l.valid = 1'b0;
    end
    return l;
  endfunction

  // more than one key's worth of low bits
  function automatic logic is_multi(input logic [CodeW-1:0] c);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < CodeW; i++) begin
      n = n + {3'd0, ~c[i]};
    end
    return n > 4'd2;
  endfunction

endpackage

`default_nettype wire

// File: design/kpte_classify.sv
// kpte_classify: combinational event decision for one scan sample.
// Depends on kpte_pkg for state, result types and scan-code helpers.
`default_nettype none

module kpte_classify (
  input  kpte_pkg::state_t            st,
  input  kpte_pkg::cfg_t              cfg,
  input  logic [kpte_pkg::CodeW-1:0] sample_code,
  input  logic [kpte_pkg::TimeW-1:0] now_ms,
  output kpte_pkg::state_t            st_next,
  output logic                        res_valid,
  output kpte_pkg::result_t           res
);
  import kpte_pkg::*;

  loc_t             loc;
  ev_t              kind;
  logic [7:0]       taps;
  logic [TimeW-1:0] long_due;
  logic [TimeW-1:0] repeat_due;

  assign long_due   = now_ms + {{(TimeW-PeriodW){1'b0}}, cfg.long_period};
  assign repeat_due = now_ms + {{(TimeW-PeriodW){1'b0}}, cfg.multi_window};

  always_comb begin
    st_next   = st;
    res_valid = 1'b0;
    kind      = EV_KEY_DOWN;
    taps      = 8'd0;
    loc       = '0;
    priority if (st.long_armed && now_ms >= st.long_deadline) begin
      // long tap wins and swallows this sample
      st_next.long_armed = 1'b0;
      res_valid          = 1'b1;
      kind               = EV_LONG_TAP;
      loc                = locate(st.held_code);
    end else if (sample_code != st.held_code) begin
      st_next.older_code = st.prior_code;
      st_next.prior_code = st.held_code;
      st_next.held_code  = sample_code;
      res_valid          = 1'b1;
      priority if (sample_code == NO_KEY) begin
        if (!is_multi(st.held_code) && st.prior_code == NO_KEY) begin
          loc = locate(st.held_code);
        end
        st_next.long_armed = 1'b0;
        kind               = EV_KEY_UP;
      end else if (!is_multi(sample_code) && st.held_code == NO_KEY) begin
        st_next.long_deadline   = long_due;
        st_next.long_armed      = 1'b1;
        st_next.repeat_deadline = repeat_due;
        loc                     = locate(sample_code);
        if (sample_code == st.prior_code && now_ms < st.repeat_deadline) begin
          st_next.repeat_count = st.repeat_count + 8'd1;
          taps                 = st.repeat_count + 8'd1;
          kind                 = EV_MULTI_TAP;
        end else begin
          st_next.repeat_count = 8'd0;
          kind                 = EV_KEY_DOWN;
        end
      end else begin
        st_next.repeat_count = 8'd0;
        st_next.long_armed   = 1'b0;
        kind                 = EV_MULTI_KEY;
      end
    end
  end

  always_comb begin
    res.kind           = kind;
    res.key_code       = st_next.held_code;
    res.previous_code  = st_next.prior_code;
    res.earlier_code   = st_next.older_code;
    res.key_position   = loc.pos;
    res.position_valid = loc.valid;
    res.tap_count      = taps;
  end

endmodule

`default_nettype wire

// File: design/kpte_state.sv
// kpte_state: history, tap counter, deadline and configuration registers.
// Depends on kpte_pkg for the state and configuration types.
`default_nettype none

module kpte_state (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         update,
  input  kpte_pkg::state_t             st_next,
  input  logic                         cfg_we,
  input  logic [0:0]                   cfg_index,
  input  logic [kpte_pkg::PeriodW-1:0] cfg_data,
  output kpte_pkg::state_t             st,
  output kpte_pkg::cfg_t               cfg
);
  import kpte_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      st.held_code       <= NO_KEY;
      st.prior_code      <= NO_KEY;
      st.older_code      <= NO_KEY;
      st.repeat_count    <= 8'd0;
      st.long_deadline   <= '0;
      st.repeat_deadline <= '0;
      st.long_armed      <= 1'b0;
    end else if (update) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.long_period  <= 16'd1000;
      cfg.multi_window <= 16'd1000;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_LONG_PERIOD:  cfg.long_period  <= cfg_data;
        CFG_MULTI_WINDOW: cfg.multi_window <= cfg_data;
        default:          ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: design/keypad_tap_event_classifier_unit.sv
// keypad_tap_event_classifier_unit: top level with input and result registers.
// Depends on kpte_pkg, kpte_classify and kpte_state.
//
// Usage:
//   s_* takes one beat per scan sample: sample code and millisecond time.
//   m_* gives one beat per event; a sample that causes no event gives none.
//   cfg_we/cfg_index/cfg_data write the long-tap period (index 0) and the
//   multi-tap window (index 1); write them only while the unit is idle.
// Timing:
//   a sample is held in the input register, classified by one pass of
//   combinational logic, and its event lands in the result register,
//   which drives m_tvalid and the event beat.
//   Throughput is one sample per cycle while no event waits on m_tready;
//   the state update of one sample is ready for the next in the same
//   cycle it is written.
// Reset: history codes go to no key, tap count and deadlines to zero, long
//   tap disarmed, both periods to 1000 ms; both registers empty.
// Stall: while m_tready is low and an event waits, the input register still
//   takes one more sample, then s_tready drops until the event is taken.
`default_nettype none

module keypad_tap_event_classifier_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // sample_code [7:0], now_ms [39:8]
  input  logic [kpte_pkg::InDataW-1:0]  s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // key_code [7:0], previous_code [15:8], earlier_code [23:16],
  // key_position [27:24], position_valid [28], tap_count [36:29], zero [39:37]
  output logic [kpte_pkg::OutDataW-1:0] m_tdata,
  // event_kind [2:0]
  output logic [kpte_pkg::KindW-1:0]    m_tuser,
  input  logic                          cfg_we,
  input  logic [0:0]                    cfg_index,
  input  logic [kpte_pkg::PeriodW-1:0]  cfg_data
);
  import kpte_pkg::*;

  logic             in_valid;
  logic [CodeW-1:0] in_code;
  logic [TimeW-1:0] in_now;
  logic             advance;
  state_t           st;
  state_t           st_next;
  cfg_t             cfg;
  logic             res_valid;
  result_t          res;
  result_t          out_res;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_code <= s_tdata[CodeW-1:0];
      in_now  <= s_tdata[CodeW +: TimeW];
    end
  end

  kpte_classify u_classify (
    .st          (st),
    .cfg         (cfg),
    .sample_code (in_code),
    .now_ms      (in_now),
    .st_next     (st_next),
    .res_valid   (res_valid),
    .res         (res)
  );

  kpte_state u_state (
    .clk       (clk),
    .rst       (rst),
    .update    (advance),
    .st_next   (st_next),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .st        (st),
    .cfg       (cfg)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (advance && res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tuser = out_res.kind;
  assign m_tdata = {3'd0, out_res.tap_count, out_res.position_valid, out_res.key_position,
                    out_res.earlier_code, out_res.previous_code, out_res.key_code};

  // long tap is only ever armed for a lone key pressed from no key
  a_armed_single: assert property (@(posedge clk) disable iff (rst)
    st.long_armed |-> (st.held_code != NO_KEY && st.prior_code == NO_KEY))
    else $error("long tap armed without a lone held key");

  a_multi_key_no_pos: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == EV_MULTI_KEY) |-> (!out_res.position_valid
      && out_res.tap_count == 8'd0))
    else $error("multi-key event names a key or carries taps");

  a_taps_multi_only: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_res.tap_count != 8'd0) |-> (m_tuser == EV_MULTI_TAP))
    else $error("tap count on an event other than multi tap");

  a_key_up_code: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == EV_KEY_UP) |-> (out_res.key_code == NO_KEY))
    else $error("key up event with a key still held");

  // a sample leaves the input register only when the result slot is free
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> ($stable(out_res) || !$past(m_tvalid)))
    else $error("waiting event overwritten");

endmodule

`default_nettype wire
